// ===== src/gmfb_pkg.sv =====
package gmfb_pkg;

	localparam int SEQ_W      = 21;
	localparam int IDX_W      = 20;
	localparam int DIM_W      = 11;
	localparam int THR_W      = 31;
	localparam int N_W        = 23;
	localparam int SQ_W       = 62;
	localparam int FIFO_DEPTH = 16;   // power of two

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_COORD_BITS = 32;

	localparam logic [THR_W-1:0] THR_RESET = 31'd655;
	localparam logic [DIM_W-1:0] W_RESET   = 11'd640;
	localparam logic [DIM_W-1:0] H_RESET   = 11'd480;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             busy;
		logic [SEQ_W-1:0] k;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] w;
		logic [N_W-1:0]   n;
		logic [THR_W-1:0] thr;
		logic [SQ_W-1:0]  thr_sq;
	} seq_t;

	typedef struct packed {
		logic [IDX_W-1:0] third;
		logic [IDX_W-1:0] second;
		logic [IDX_W-1:0] first;
		logic             last;
	} face_t;

endpackage

// ===== src/grid_mesh_face_builder_unit.sv =====
// Grid mesh face builder.
// Input stream (s_*): one item per grid vertex in raster order, then one
// drain item per column to flush the last row. s_tuser is the mode (drain
// when high). Output stream (m_*): faces as three vertex indices; m_tlast
// marks the last face produced by one input item.
// Config port: cfg_we writes register cfg_index (0 threshold, 1 width,
// 2 height) with cfg_data; write only while the block is idle.
// Throughput: one input item per cycle while s_tready is high. Each item
// yields zero to two faces and the output drains one face per cycle while
// m_tready is high, so a run of two-face items is paced by the output port
// through a 16-face output queue. Faces are registered through the
// line-store read, the edge checks and the output queue before they are
// offered. The line stores are read at four neighbors per cycle from two
// copies, each with two read ports. After reset and after every config
// write, s_tready stays low while the current column is recomputed. When
// the receiver stalls the queue fills and s_tready drops once the
// in-flight items could overflow it; nothing is dropped.
module grid_mesh_face_builder_unit
	import gmfb_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [103:0]     s_tdata,   // pos_x, pos_y, pos_z, point_valid, zero fill
	input  logic [0:0]       s_tuser,   // mode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata,   // first_vertex, second_vertex, third_vertex, zero fill
	output logic             m_tlast,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [THR_W-1:0] cfg_data
);

	localparam int DEPTH = 2 * MAX_WIDTH + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = COORD_BITS;
	localparam int DW    = 3 * CB + 1;
	localparam int FCW   = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic             f1;
		logic             f2;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] below;
		logic [IDX_W-1:0] right;
		logic [IDX_W-1:0] above;
		logic [IDX_W-1:0] left;
	} meta_t;

	typedef struct packed {
		logic vc;
		logic vbelow;
		logic vright;
		logic vabove;
		logic vleft;
	} vflags_t;

	function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] s, input logic [AW:0] off);
		logic [AW+1:0] t;
		t = (AW+2)'(s) + (AW+2)'(DEPTH) - (AW+2)'(off);
		if (t >= (AW+2)'(DEPTH)) t = t - (AW+2)'(DEPTH);
		return t[AW-1:0];
	endfunction

	seq_t          st;
	logic [AW-1:0] slot;
	logic          accept, cur_valid, credit_ok;
	logic [DW-1:0] wdata;
	logic [AW-1:0] a_right, a_c, a_left, a_above;
	logic [DW-1:0] rd_right, rd_c, rd_left, rd_above;
	logic [N_W-1:0] kx, wx;
	logic          proc;
	meta_t         meta_s0, meta_s1, meta_s2, meta_s3, meta_s4;
	logic          v_s1, v_s2, v_s3, v_s4;
	logic [DW-1:0] cur_s1;
	vflags_t       vf_s1, vf_s2, vf_s3, vf_s4;
	logic [5:0]    ok_s4;
	logic          f1_ok, f2_ok;
	face_t         face1, face2, push0, head;
	logic [1:0]    push_cnt;
	logic [FCW-1:0] fifo_cnt;
	logic [6:0]    need;

	gmfb_seq #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .DEPTH(DEPTH), .AW(AW)
	) u_seq (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .advance(accept), .st(st), .slot(slot)
	);

	// two queued face slots are reserved for every item still in flight and for the item being accepted
	always_comb begin
		need = 7'(fifo_cnt) + 7'd2 * (7'(v_s1) + 7'(v_s2) + 7'(v_s3) + 7'(v_s4)) + 7'd2;
		credit_ok = need <= 7'(FIFO_DEPTH);
	end

	assign s_tready = !st.busy && credit_ok;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		kx        = N_W'(st.k);
		wx        = N_W'(st.w);
		cur_valid = !s_tuser[0] && s_tdata[96] && (kx < st.n);
		wdata     = {cur_valid, s_tdata[64 +: CB], s_tdata[32 +: CB], s_tdata[0 +: CB]};
		a_right   = ring_sub(slot, (AW+1)'(st.w) - (AW+1)'(1));
		a_c       = ring_sub(slot, (AW+1)'(st.w));
		a_left    = ring_sub(slot, (AW+1)'(st.w) + (AW+1)'(1));
		a_above   = ring_sub(slot, (AW+1)'(st.w) + (AW+1)'(st.w));
		proc        = (kx >= wx) && ((kx - wx) < st.n);
		meta_s0.f1  = proc && (kx < st.n) && ((DIM_W+1)'(st.col) + (DIM_W+1)'(1) < (DIM_W+1)'(st.w));
		meta_s0.f2  = proc && (kx >= wx + wx) && (st.col != '0);
		meta_s0.c     = IDX_W'(st.k - SEQ_W'(st.w));
		meta_s0.below = IDX_W'(st.k);
		meta_s0.right = meta_s0.c + IDX_W'(1);
		meta_s0.above = meta_s0.c - IDX_W'(st.w);
		meta_s0.left  = meta_s0.c - IDX_W'(1);
	end

	gmfb_store #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_store_a (
		.clk(clk), .we(accept), .waddr(slot), .wdata(wdata),
		.raddr0(a_right), .raddr1(a_c), .rdata0(rd_right), .rdata1(rd_c)
	);

	gmfb_store #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_store_b (
		.clk(clk), .we(accept), .waddr(slot), .wdata(wdata),
		.raddr0(a_left), .raddr1(a_above), .rdata0(rd_left), .rdata1(rd_above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1 <= meta_s0;
		cur_s1  <= wdata;
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
		vf_s2   <= vf_s1;
		vf_s3   <= vf_s2;
		vf_s4   <= vf_s3;
	end

	always_comb begin
		vf_s1.vc     = rd_c[DW-1];
		vf_s1.vbelow = cur_s1[DW-1];
		vf_s1.vright = rd_right[DW-1];
		vf_s1.vabove = rd_above[DW-1];
		vf_s1.vleft  = rd_left[DW-1];
	end

	// edges: c-below, below-right, right-c, c-above, above-left, left-c
	gmfb_edge #(.COORD_BITS(CB)) u_e0 (
		.clk(clk), .ax(rd_c[0 +: CB]), .ay(rd_c[CB +: CB]), .az(rd_c[2*CB +: CB]),
		.bx(cur_s1[0 +: CB]), .by(cur_s1[CB +: CB]), .bz(cur_s1[2*CB +: CB]),
		.thr(st.thr), .thr_sq(st.thr_sq), .ok(ok_s4[0])
	);
	gmfb_edge #(.COORD_BITS(CB)) u_e1 (
		.clk(clk), .ax(cur_s1[0 +: CB]), .ay(cur_s1[CB +: CB]), .az(cur_s1[2*CB +: CB]),
		.bx(rd_right[0 +: CB]), .by(rd_right[CB +: CB]), .bz(rd_right[2*CB +: CB]),
		.thr(st.thr), .thr_sq(st.thr_sq), .ok(ok_s4[1])
	);
	gmfb_edge #(.COORD_BITS(CB)) u_e2 (
		.clk(clk), .ax(rd_right[0 +: CB]), .ay(rd_right[CB +: CB]), .az(rd_right[2*CB +: CB]),
		.bx(rd_c[0 +: CB]), .by(rd_c[CB +: CB]), .bz(rd_c[2*CB +: CB]),
		.thr(st.thr), .thr_sq(st.thr_sq), .ok(ok_s4[2])
	);
	gmfb_edge #(.COORD_BITS(CB)) u_e3 (
		.clk(clk), .ax(rd_c[0 +: CB]), .ay(rd_c[CB +: CB]), .az(rd_c[2*CB +: CB]),
		.bx(rd_above[0 +: CB]), .by(rd_above[CB +: CB]), .bz(rd_above[2*CB +: CB]),
		.thr(st.thr), .thr_sq(st.thr_sq), .ok(ok_s4[3])
	);
	gmfb_edge #(.COORD_BITS(CB)) u_e4 (
		.clk(clk), .ax(rd_above[0 +: CB]), .ay(rd_above[CB +: CB]), .az(rd_above[2*CB +: CB]),
		.bx(rd_left[0 +: CB]), .by(rd_left[CB +: CB]), .bz(rd_left[2*CB +: CB]),
		.thr(st.thr), .thr_sq(st.thr_sq), .ok(ok_s4[4])
	);
	gmfb_edge #(.COORD_BITS(CB)) u_e5 (
		.clk(clk), .ax(rd_left[0 +: CB]), .ay(rd_left[CB +: CB]), .az(rd_left[2*CB +: CB]),
		.bx(rd_c[0 +: CB]), .by(rd_c[CB +: CB]), .bz(rd_c[2*CB +: CB]),
		.thr(st.thr), .thr_sq(st.thr_sq), .ok(ok_s4[5])
	);

	always_comb begin
		f1_ok = v_s4 && meta_s4.f1 && vf_s4.vc && vf_s4.vbelow && vf_s4.vright
			&& (&ok_s4[2:0]);
		f2_ok = v_s4 && meta_s4.f2 && vf_s4.vc && vf_s4.vabove && vf_s4.vleft
			&& (&ok_s4[5:3]);
		face1.first  = meta_s4.c;
		face1.second = meta_s4.below;
		face1.third  = meta_s4.right;
		face1.last   = !f2_ok;
		face2.first  = meta_s4.c;
		face2.second = meta_s4.above;
		face2.third  = meta_s4.left;
		face2.last   = 1'b1;
		push0        = f1_ok ? face1 : face2;
		push_cnt     = 2'(f1_ok) + 2'(f2_ok);
	end

	gmfb_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push_cnt(push_cnt), .push0(push0), .push1(face2),
		.pop(m_tvalid && m_tready), .head(head), .not_empty(m_tvalid), .count(fifo_cnt)
	);

	assign m_tdata = {4'b0, head.third, head.second, head.first};
	assign m_tlast = head.last;

endmodule

// ===== src/gmfb_store.sv =====
module gmfb_store
	import gmfb_pkg::*;
#(
	parameter int DEPTH = 2 * DEF_MAX_WIDTH + 1,
	parameter int AW    = $clog2(2 * DEF_MAX_WIDTH + 1),
	parameter int DW    = 3 * DEF_COORD_BITS + 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [DW-1:0] rdata0,
	output logic [DW-1:0] rdata1
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ===== src/gmfb_edge.sv =====
module gmfb_edge
	import gmfb_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] az,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	input  logic signed [COORD_BITS-1:0] bz,
	input  logic [THR_W-1:0]             thr,
	input  logic [SQ_W-1:0]              thr_sq,
	output logic                         ok
);

	localparam int AB = COORD_BITS + 1;
	localparam int CW = (AB > THR_W) ? AB : THR_W;

	logic signed [AB-1:0] dx, dy, dz;
	logic [AB-1:0]        adx, ady, adz;
	logic                 over;
	logic [THR_W-1:0]     mx_s2, my_s2, mz_s2;
	logic                 over_s2;
	logic [SQ_W-1:0]      sx_s3, sy_s3, sz_s3;
	logic                 over_s3;
	logic [SQ_W+1:0]      sum;

	always_comb begin
		dx = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
		dy = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
		dz = {az[COORD_BITS-1], az} - {bz[COORD_BITS-1], bz};
		adx = dx[AB-1] ? AB'(-dx) : AB'(dx);
		ady = dy[AB-1] ? AB'(-dy) : AB'(dy);
		adz = dz[AB-1] ? AB'(-dz) : AB'(dz);
		over = (CW'(adx) > CW'(thr)) || (CW'(ady) > CW'(thr)) || (CW'(adz) > CW'(thr));
	end

	// squares only matter when every delta fits under the threshold
	always_ff @(posedge clk) begin
		mx_s2   <= THR_W'(adx);
		my_s2   <= THR_W'(ady);
		mz_s2   <= THR_W'(adz);
		over_s2 <= over;
	end

	always_ff @(posedge clk) begin
		sx_s3   <= SQ_W'(mx_s2) * SQ_W'(mx_s2);
		sy_s3   <= SQ_W'(my_s2) * SQ_W'(my_s2);
		sz_s3   <= SQ_W'(mz_s2) * SQ_W'(mz_s2);
		over_s3 <= over_s2;
	end

	assign sum = (SQ_W+2)'(sx_s3) + (SQ_W+2)'(sy_s3) + (SQ_W+2)'(sz_s3);

	always_ff @(posedge clk) begin
		ok <= !over_s3 && (sum <= (SQ_W+2)'(thr_sq));
	end

endmodule

// ===== src/gmfb_seq.sv =====
module gmfb_seq
	import gmfb_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int DEPTH      = 2 * DEF_MAX_WIDTH + 1,
	parameter int AW         = $clog2(2 * DEF_MAX_WIDTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [THR_W-1:0] cfg_data,
	input  logic             advance,
	output seq_t             st,
	output logic [AW-1:0]    slot
);

	localparam int CNT_W = $clog2(SEQ_W + 2);
	localparam int BIT_W = $clog2(SEQ_W);
	localparam logic [CNT_W-1:0] CNT_START = CNT_W'(SEQ_W + 1);

	logic [THR_W-1:0] thr_q;
	logic [DIM_W-1:0] w_q, h_q, w_eff, h_eff;
	logic [SEQ_W-1:0] k_q;
	logic [DIM_W-1:0] col_q, rem_q, rem_next;
	logic [AW-1:0]    slot_q;
	logic [N_W-1:0]   n_q, k1;
	logic [SQ_W-1:0]  thr_sq_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BIT_W-1:0] bit_idx;
	logic [DIM_W:0]   r2;
	logic             frame_end;

	always_comb begin
		if (w_q == '0) w_eff = DIM_W'(1);
		else if (32'(w_q) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
		else w_eff = w_q;
		if (h_q == '0) h_eff = DIM_W'(1);
		else if (32'(h_q) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
		else h_eff = h_q;
	end

	always_ff @(posedge clk) begin
		n_q      <= N_W'(w_eff) * N_W'(h_eff);
		thr_sq_q <= SQ_W'(thr_q) * SQ_W'(thr_q);
	end

	// column of k recomputed bit-serially after reset and after every config write
	always_comb begin
		bit_idx  = BIT_W'(cnt_q - CNT_W'(1));
		r2       = {rem_q, k_q[bit_idx]};
		rem_next = (r2 >= {1'b0, w_eff}) ? DIM_W'(r2 - {1'b0, w_eff}) : DIM_W'(r2);
		k1        = N_W'(k_q) + N_W'(1);
		frame_end = k1 >= (n_q + N_W'(w_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			w_q    <= W_RESET;
			h_q    <= H_RESET;
			k_q    <= '0;
			col_q  <= '0;
			slot_q <= '0;
			rem_q  <= '0;
			cnt_q  <= CNT_START;
		end else if (cfg_we) begin
			cnt_q <= CNT_START;
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: thr_q <= cfg_data;
				REG_WIDTH:     w_q   <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:    h_q   <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end else if (cnt_q == CNT_START) begin
			rem_q <= '0;
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (cnt_q != '0) begin
			rem_q <= rem_next;
			if (cnt_q == CNT_W'(1)) col_q <= rem_next;
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (advance) begin
			if (frame_end) begin
				k_q    <= '0;
				col_q  <= '0;
				slot_q <= '0;
			end else begin
				k_q    <= SEQ_W'(k1);
				col_q  <= (col_q + DIM_W'(1) == w_eff) ? '0 : col_q + DIM_W'(1);
				slot_q <= (32'(slot_q) + 1 == DEPTH) ? '0 : slot_q + AW'(1);
			end
		end
	end

	always_comb begin
		st.busy   = cnt_q != '0;
		st.k      = k_q;
		st.col    = col_q;
		st.w      = w_eff;
		st.n      = n_q;
		st.thr    = thr_q;
		st.thr_sq = thr_sq_q;
		slot      = slot_q;
	end

endmodule

// ===== src/gmfb_fifo.sv =====
module gmfb_fifo
	import gmfb_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_cnt,
	input  face_t                      push0,
	input  face_t                      push1,
	input  logic                       pop,
	output face_t                      head,
	output logic                       not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	face_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2) mem_q[wr_q + PW'(1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push_cnt);
			if (pop) rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end

	assign head      = mem_q[rd_q];
	assign not_empty = cnt_q != '0;
	assign count     = cnt_q;

endmodule

// ===== tb/grid_mesh_face_builder_unit_tb.sv =====
module grid_mesh_face_builder_unit_tb;
	import gmfb_pkg::*;

	localparam int RING = 2 * DEF_MAX_WIDTH + 1;
	localparam int CYCLE_LIMIT = 2500000;
	localparam int unsigned WHOLE = 32'hFFFFFFFF;

	typedef struct {
		bit          drain;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		bit          pv;
	} vertex_t;

	typedef struct {
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] second;
		logic [IDX_W-1:0] third;
		bit               last;
	} tri_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [103:0]     s_tdata;
	logic [0:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [63:0]      m_tdata;
	logic             m_tlast;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [THR_W-1:0] cfg_data;

	grid_mesh_face_builder_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the block
	logic [THR_W-1:0] thr_reg;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	longint           ring_x [RING];
	longint           ring_y [RING];
	longint           ring_z [RING];
	bit               ring_v [RING];
	int unsigned      vtx_seq;

	vertex_t pending_vtx[$];
	tri_t    faces_due[$];

	int  errors;
	int  faces_seen;
	int  items_sent;
	int  frames_run;
	int  cycles;
	bit  in_fire;
	bit  quiet;
	int  send_gap;
	int  rdy_gap;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return 32'(v);
	endfunction

	function automatic bit edge_fits(int sa, int sb);
		longint unsigned t, dx, dy, dz;
		longint d;
		t = thr_reg;
		d = ring_x[sa] - ring_x[sb]; dx = (d < 0) ? -d : d;
		d = ring_y[sa] - ring_y[sb]; dy = (d < 0) ? -d : d;
		d = ring_z[sa] - ring_z[sb]; dz = (d < 0) ? -d : d;
		if (dx > t || dy > t || dz > t) return 0;
		return dx * dx + dy * dy + dz * dz <= t * t;
	endfunction

	function automatic bit tri_fits(int unsigned a, int unsigned b, int unsigned c);
		int sa, sb, sc;
		sa = a % RING; sb = b % RING; sc = c % RING;
		if (!ring_v[sa] || !ring_v[sb] || !ring_v[sc]) return 0;
		return edge_fits(sa, sb) && edge_fits(sb, sc) && edge_fits(sc, sa);
	endfunction

	function automatic void build_faces(vertex_t v);
		int unsigned w, h, n, k, c, row, col, slot;
		int          cnt;
		tri_t        f;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		n = w * h;
		k = vtx_seq;
		slot = k % RING;
		cnt = 0;
		ring_x[slot] = longint'($signed(v.x));
		ring_y[slot] = longint'($signed(v.y));
		ring_z[slot] = longint'($signed(v.z));
		ring_v[slot] = !v.drain && v.pv && k < n;
		if (k >= w && k - w < n) begin
			c = k - w;
			row = c / w;
			col = c % w;
			if (row + 1 < h && col + 1 < w && tri_fits(c, c + w, c + 1)) begin
				f.first = IDX_W'(c); f.second = IDX_W'(c + w); f.third = IDX_W'(c + 1);
				f.last = 0;
				faces_due.push_back(f);
				cnt++;
			end
			if (row >= 1 && col >= 1 && tri_fits(c, c - w, c - 1)) begin
				f.first = IDX_W'(c); f.second = IDX_W'(c - w); f.third = IDX_W'(c - 1);
				f.last = 0;
				faces_due.push_back(f);
				cnt++;
			end
			if (cnt > 0) faces_due[$].last = 1;
		end
		vtx_seq = (k + 1 >= n + w) ? 0 : ((k + 1) & 32'h1FFFFF);
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("MISMATCH %s: got %0d expected %0d (face %0d)", what, got, want, faces_seen);
		errors++;
	endtask

	// monitor: input accepts feed the predictor, output faces are checked
	always @(posedge clk) begin
		tri_t f;
		cycles++;
		in_fire = s_tvalid && s_tready;
		if (in_fire) begin
			vertex_t v;
			v.drain = s_tuser[0];
			v.x = s_tdata[31:0];
			v.y = s_tdata[63:32];
			v.z = s_tdata[95:64];
			v.pv = s_tdata[96];
			build_faces(v);
		end
		if (m_tvalid && m_tready) begin
			if (faces_due.size() == 0) begin
				report_mismatch("unexpected face, first vertex", 32'(m_tdata[19:0]), 0);
			end else begin
				f = faces_due.pop_front();
				if (m_tdata[19:0] != f.first)
					report_mismatch("first", 32'(m_tdata[19:0]), 32'(f.first));
				if (m_tdata[39:20] != f.second)
					report_mismatch("second", 32'(m_tdata[39:20]), 32'(f.second));
				if (m_tdata[59:40] != f.third)
					report_mismatch("third", 32'(m_tdata[59:40]), 32'(f.third));
				if (m_tlast != f.last)
					report_mismatch("last", 32'(m_tlast), 32'(f.last));
			end
			faces_seen++;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout with %0d faces outstanding", faces_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// vertex driver
	always @(negedge clk) begin
		vertex_t v;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_fire) begin
			// hold the item
		end else if (send_gap > 0) begin
			s_tvalid <= 1'b0;
			send_gap--;
		end else if (pending_vtx.size() > 0) begin
			v = pending_vtx.pop_front();
			s_tvalid <= 1'b1;
			s_tuser <= v.drain;
			s_tdata <= {7'd0, v.pv, v.z, v.y, v.x};
			items_sent++;
			send_gap = pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// face receiver
	always @(negedge clk) begin
		if (rdy_gap > 0) begin
			m_tready <= 1'b0;
			rdy_gap--;
		end else begin
			m_tready <= 1'b1;
			rdy_gap = pick_gap();
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [THR_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_THRESHOLD: thr_reg = val;
			REG_WIDTH: width_reg = val[DIM_W-1:0];
			default: height_reg = val[DIM_W-1:0];
		endcase
	endtask

	task automatic wait_idle();
		while (pending_vtx.size() > 0 || s_tvalid || faces_due.size() > 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic logic [31:0] near(longint base, int jit);
		return 32'(base + $signed($urandom_range(0, 2 * jit)) - jit);
	endfunction

	// one frame: grid items then drain items, cut short at max_items;
	// noise mixes in stray kinds and random coordinates
	task automatic queue_frame(int noise, int unsigned max_items);
		int unsigned w, h, n, sp, r;
		vertex_t v;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		n = w * h;
		sp = 32'(thr_reg) / 2;
		for (int unsigned k = 0; k < n + w && k < max_items; k++) begin
			r = $urandom_range(0, 99);
			v.drain = (k >= n);
			if (r < noise) v.drain = !v.drain;
			v.pv = ($urandom_range(0, 7) != 0);
			if (r >= 100 - noise) begin
				v.x = $urandom; v.y = $urandom; v.z = $urandom;
			end else begin
				v.x = near(longint'(k % w) * sp, sp / 2 + 1);
				v.y = near(longint'(k / w) * sp - 64'sd20000, sp / 2 + 1);
				v.z = near(longint'($urandom_range(0, 3)) * sp, sp + 1);
			end
			pending_vtx.push_back(v);
		end
		frames_run++;
	endtask

	initial begin
		vertex_t v;
		logic [31:0] ext [4];
		int unsigned sent_mark;
		errors = 0; faces_seen = 0; items_sent = 0; frames_run = 0; cycles = 0;
		in_fire = 0; quiet = 0; send_gap = 0; rdy_gap = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0; cfg_index = REG_THRESHOLD; cfg_data = '0;
		thr_reg = THR_RESET; width_reg = W_RESET; height_reg = H_RESET;
		vtx_seq = 0;
		foreach (ring_v[i]) begin
			ring_x[i] = 0; ring_y[i] = 0; ring_z[i] = 0; ring_v[i] = 0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed 3x3 frame: coordinate extremes, invalid points, stray kinds
		write_reg(REG_THRESHOLD, 31'h7FFFFFFF);
		write_reg(REG_WIDTH, THR_W'(3));
		write_reg(REG_HEIGHT, THR_W'(3));
		ext[0] = 32'h80000000; ext[1] = 32'h7FFFFFFF; ext[2] = 32'h00000000; ext[3] = 32'hFFFFFFFF;
		for (int k = 0; k < 12; k++) begin
			v.drain = (k >= 9);
			v.pv = (k != 4);
			v.x = (k < 4) ? ext[k] : 32'(k * 100);
			v.y = (k < 4) ? ext[3 - k] : 32'(-k * 50);
			v.z = (k == 8) ? 32'h40000000 : 32'(k);
			if (k == 6) v.drain = 1;   // drain tick inside the grid
			if (k == 10) v.drain = 0;  // vertex inside the drain
			pending_vtx.push_back(v);
		end
		frames_run++;
		wait_idle();

		// extreme settings, kept short in item count
		write_reg(REG_THRESHOLD, '0);
		write_reg(REG_WIDTH, THR_W'(0));
		write_reg(REG_HEIGHT, THR_W'(5));
		queue_frame(5, WHOLE);
		wait_idle();
		// oversized dimensions clamp to the maximum; the frame is left early
		write_reg(REG_THRESHOLD, THR_W'(4000));
		write_reg(REG_WIDTH, THR_W'(2047));
		write_reg(REG_HEIGHT, THR_W'(2047));
		queue_frame(3, 1100);
		wait_idle();
		// a tiny grid makes the next item close the abandoned frame
		write_reg(REG_WIDTH, THR_W'(1));
		write_reg(REG_HEIGHT, THR_W'(1));
		v.drain = 1; v.pv = 0; v.x = '0; v.y = '0; v.z = '0;
		pending_vtx.push_back(v);
		wait_idle();

		// random frames, mostly small
		sent_mark = items_sent;
		while (items_sent - sent_mark < 700) begin
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: write_reg(REG_THRESHOLD, THR_W'($urandom_range(1, 64)));
				1: write_reg(REG_THRESHOLD, THR_W'($urandom_range(100, 100000)));
				2: write_reg(REG_THRESHOLD, THR_W'($urandom_range(1 << 20, 1 << 30)));
				default: write_reg(REG_THRESHOLD, THR_W'({$urandom} >> 1));
			endcase
			write_reg(REG_WIDTH, THR_W'($urandom_range(1, 12)));
			write_reg(REG_HEIGHT, THR_W'($urandom_range(1, 10)));
			queue_frame(($urandom_range(0, 4) == 0) ? 15 : 2, WHOLE);
			wait_idle();
		end
		quiet = 0;

		$display("Covered %0d frames, %0d items in, %0d faces checked over %0d cycles",
			frames_run, items_sent, faces_seen, cycles);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
